// File: hdl/lcme_pkg.sv
// ----------------------------------------------------------------------------
// lcme_pkg
// Types, codes and helpers for the logical / compare / move execute block.
// ----------------------------------------------------------------------------
package lcme_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned InDataW  = 168;  // 161 payload bits, byte padded
  localparam int unsigned OutDataW = 104;  // 103 payload bits, byte padded

  // Status word flag positions
  localparam int unsigned FlagN = 31;
  localparam int unsigned FlagZ = 30;
  localparam int unsigned FlagC = 29;
  localparam int unsigned FlagV = 28;

  localparam logic [RegIdxW-1:0] PcIndex = 4'd15;

  localparam logic [DataW-1:0] Rev16LoMask = 32'h00FF00FF;
  localparam logic [DataW-1:0] Rev16HiMask = 32'hFF00FF00;
  localparam logic [DataW-1:0] HalfLoMask  = 32'h0000FFFF;

  typedef enum logic [3:0] {
    OP_ORR   = 4'd0,
    OP_BIC   = 4'd1,
    OP_AND   = 4'd2,
    OP_TST   = 4'd3,
    OP_CMP   = 4'd4,
    OP_MOV   = 4'd5,
    OP_RSB   = 4'd6,
    OP_CMN   = 4'd7,
    OP_MOVW  = 4'd8,
    OP_MOVT  = 4'd9,
    OP_REV   = 4'd10,
    OP_REV16 = 4'd11,
    OP_REVSH = 4'd12,
    OP_RBIT  = 4'd13
  } op_e;

  typedef enum logic [3:0] {
    CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
    CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
    CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } cond_e;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [DataW-1:0]   status_out;
    logic [DataW-1:0]   branch_target;
    logic               branch_taken;
    logic [DataW-1:0]   write_value;
    logic [RegIdxW-1:0] dest_index;
    logic               reg_write;
    logic               executed;
  } result_t;

  function automatic logic cond_passes(input logic [3:0] cond, input logic [DataW-1:0] st);
    logic n, z, c, v, pass;
    n = st[FlagN];
    z = st[FlagZ];
    c = st[FlagC];
    v = st[FlagV];
    case (cond)
      CC_EQ:   pass = z;
      CC_NE:   pass = !z;
      CC_CS:   pass = c;
      CC_CC:   pass = !c;
      CC_MI:   pass = n;
      CC_PL:   pass = !n;
      CC_VS:   pass = v;
      CC_VC:   pass = !v;
      CC_HI:   pass = c && !z;
      CC_LS:   pass = !c || z;
      CC_GE:   pass = (n == v);
      CC_LT:   pass = (n != v);
      CC_GT:   pass = !z && (n == v);
      CC_LE:   pass = z || (n != v);
      default: pass = 1'b1;
    endcase
    return pass;
  endfunction

  function automatic logic [DataW-1:0] set_nz(input logic [DataW-1:0] st,
                                              input logic [DataW-1:0] res);
    logic [DataW-1:0] r;
    r        = st;
    r[FlagN] = res[DataW-1];
    r[FlagZ] = (res == '0);
    return r;
  endfunction

endpackage

// File: hdl/logic_compare_move_execute.sv
// ----------------------------------------------------------------------------
// logic_compare_move_execute
// Execute stage for logical, compare, move and reversal instructions with a
// local status word and exception-return restore from saved status.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; the status word updates as
//   the result registers.
// Throughput: one transaction per cycle while the sink accepts results; the next
//   item reads the status word written by the previous one at the same edge its result is registered.
// Reset: rst_ni async active low clears valids, status word and saved status.
module logic_compare_move_execute
  import lcme_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: saved status
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [DataW-1:0]    cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [31:0] instruction_word, [63:32] first_operand, [95:64] reverse_source,
  // [127:96] old_destination, [159:128] shifted_operand, [160] shifter_carry
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [3:0] req_type
  input  logic [3:0]          s_axis_tuser_i,
  // output stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] executed, [1] reg_write, [5:2] dest_index, [37:6] write_value,
  // [38] branch_taken, [70:39] branch_target, [102:71] status_out
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // ---------------- input register ----------------
  logic             in_vld_q;
  logic [3:0]       req_q;
  logic [DataW-1:0] iw_q, a_q, rm_q, old_q, b_q;
  logic             shc_q;

  logic    out_vld_q;
  result_t out_q, out_d;
  logic [DataW-1:0] status_q, status_d, saved_q;
  logic    advance;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      req_q <= s_axis_tuser_i;
      iw_q  <= s_axis_tdata_i[31:0];
      a_q   <= s_axis_tdata_i[63:32];
      rm_q  <= s_axis_tdata_i[95:64];
      old_q <= s_axis_tdata_i[127:96];
      b_q   <= s_axis_tdata_i[159:128];
      shc_q <= s_axis_tdata_i[160];
    end
  end

  // ---------------- execute logic ----------------
  logic [3:0]         cond;
  logic               s_bit;
  logic [RegIdxW-1:0] rd;
  logic [15:0]        imm16;
  logic [DataW-1:0]   add_x, add_y, add_res, rbit;
  logic               add_cin;
  logic [DataW:0]     add_sum;
  logic               add_v;

  assign cond  = iw_q[31:28];
  assign s_bit = iw_q[20];
  assign rd    = iw_q[15:12];
  assign imm16 = {iw_q[19:16], iw_q[11:0]};

  // shared adder: cmp a+~b+1, rsb b+~a+1, cmn a+b
  always_comb begin
    add_x   = a_q;
    add_y   = ~b_q;
    add_cin = 1'b1;
    case (req_q)
      OP_RSB: begin
        add_x = b_q;
        add_y = ~a_q;
      end
      OP_CMN: begin
        add_y   = b_q;
        add_cin = 1'b0;
      end
      default: ;
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_cin};
  assign add_res = add_sum[DataW-1:0];
  assign add_v   = (add_x[DataW-1] == add_y[DataW-1]) && (add_res[DataW-1] != add_x[DataW-1]);

  always_comb begin
    for (int i = 0; i < DataW; i++) begin
      rbit[i] = rm_q[DataW-1-i];
    end
  end

  always_comb begin
    logic [DataW-1:0] res;
    logic             pass;
    res      = '0;
    status_d = status_q;
    out_d    = '0;
    pass     = cond_passes(cond, status_q);
    case (req_q)
      OP_REV, OP_REV16, OP_REVSH, OP_RBIT: begin
        case (req_q)
          OP_REV:   res = {rm_q[7:0], rm_q[15:8], rm_q[23:16], rm_q[31:24]};
          OP_REV16: res = ((rm_q & Rev16LoMask) << 8) | ((rm_q & Rev16HiMask) >> 8);
          OP_REVSH: res = {{16{rm_q[7]}}, rm_q[7:0], rm_q[15:8]};
          default:  res = rbit;
        endcase
        if (rd != PcIndex) begin
          out_d.executed    = 1'b1;
          out_d.reg_write   = 1'b1;
          out_d.dest_index  = rd;
          out_d.write_value = res;
        end
      end
      OP_TST, OP_CMP, OP_CMN: begin
        if (pass) begin
          out_d.executed = 1'b1;
          if (req_q == OP_TST) begin
            status_d        = set_nz(status_q, a_q & b_q);
            status_d[FlagC] = shc_q;
          end else begin
            status_d        = set_nz(status_q, add_res);
            status_d[FlagC] = add_sum[DataW];
            status_d[FlagV] = add_v;
          end
        end
      end
      OP_MOVW, OP_MOVT: begin
        if (pass) begin
          out_d.executed = 1'b1;
          res = (req_q == OP_MOVW) ? {16'h0000, imm16}
                                   : ((old_q & HalfLoMask) | {imm16, 16'h0000});
          if (rd == PcIndex) begin
            out_d.branch_taken  = 1'b1;
            out_d.branch_target = {res[DataW-1:1], 1'b0};
          end else begin
            out_d.reg_write   = 1'b1;
            out_d.dest_index  = rd;
            out_d.write_value = res;
          end
        end
      end
      OP_ORR, OP_BIC, OP_AND, OP_MOV, OP_RSB: begin
        if (pass) begin
          out_d.executed = 1'b1;
          case (req_q)
            OP_ORR:  res = a_q | b_q;
            OP_BIC:  res = a_q & ~b_q;
            OP_AND:  res = a_q & b_q;
            OP_MOV:  res = b_q;
            default: res = add_res;
          endcase
          if (rd == PcIndex) begin
            out_d.branch_taken  = 1'b1;
            out_d.branch_target = {res[DataW-1:1], 1'b0};
            if (s_bit) status_d = saved_q;  // exception return
          end else begin
            out_d.reg_write   = 1'b1;
            out_d.dest_index  = rd;
            out_d.write_value = res;
            if (s_bit) begin
              status_d = set_nz(status_q, res);
              if (req_q == OP_RSB) begin
                status_d[FlagC] = add_sum[DataW];
                status_d[FlagV] = add_v;
              end else begin
                status_d[FlagC] = shc_q;
              end
            end
          end
        end
      end
      default: ;
    endcase
    out_d.status_out = status_d;
  end

  // ---------------- result register and state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      status_q  <= '0;
      saved_q   <= '0;
    end else begin
      if (advance) begin
        status_q <= status_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        saved_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(result_t)){1'b0}}, out_q};

  // ---------------- assertions ----------------
  a_status_follows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (status_q == out_q.status_out))
    else $error("status word differs from registered status_out");

  a_status_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(status_q))
    else $error("status word changed without a transaction");

  a_write_branch_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.reg_write && out_q.branch_taken))
    else $error("register write and branch in one result");

  a_effect_needs_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.executed) |-> (!out_q.reg_write && !out_q.branch_taken))
    else $error("effect without execution");

  a_no_pc_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.reg_write) |-> (out_q.dest_index != PcIndex))
    else $error("general write to program counter index");

endmodule

// File: verif/tb_logic_compare_move_execute.sv
// ----------------------------------------------------------------------------
// tb_logic_compare_move_execute
// Self-checking bench for the logical / compare / move execute stage. A
// scoreboard class keeps its own status word and saved status, predicts the
// result of every accepted instruction and checks each output transaction
// field by field. Directed instructions hit flag and branch corner cases, then
// random phases run with and without source idling and sink back-pressure
// under several saved-status settings.
// ----------------------------------------------------------------------------
module tb_logic_compare_move_execute;
  import lcme_pkg::*;

  // selectors outside the decoded range; the block must do nothing for them
  localparam logic [3:0] OpSpareLo = 4'd14;
  localparam logic [3:0] OpSpareHi = 4'd15;

  // input payload, instruction word in the lowest bits
  typedef struct packed {
    logic             shc;
    logic [DataW-1:0] shifted;
    logic [DataW-1:0] old_dest;
    logic [DataW-1:0] rev_src;
    logic [DataW-1:0] first_op;
    logic [DataW-1:0] iw;
  } instr_bus_t;

  class exec_scoreboard;
    logic [DataW-1:0] flags_word = '0;
    logic [DataW-1:0] saved_word = '0;
    result_t          pending_results[$];
    int               mismatches = 0;
    int               checked    = 0;

    function bit cond_holds(logic [3:0] cc, logic [DataW-1:0] st);
      bit n, z, c, v;
      n = st[FlagN];
      z = st[FlagZ];
      c = st[FlagC];
      v = st[FlagV];
      case (cc)
        CC_EQ: return z;
        CC_NE: return !z;
        CC_CS: return c;
        CC_CC: return !c;
        CC_MI: return n;
        CC_PL: return !n;
        CC_VS: return v;
        CC_VC: return !v;
        CC_HI: return c && !z;
        CC_LS: return !c || z;
        CC_GE: return n == v;
        CC_LT: return n != v;
        CC_GT: return !z && (n == v);
        CC_LE: return z || (n != v);
        default: return 1'b1;
      endcase
    endfunction

    function logic [DataW-1:0] with_nz(logic [DataW-1:0] st, logic [DataW-1:0] val);
      st[FlagN] = val[DataW-1];
      st[FlagZ] = (val == '0);
      return st;
    endfunction

    function logic [DataW-1:0] bit_mirror(logic [DataW-1:0] x);
      logic [DataW-1:0] y;
      for (int i = 0; i < DataW; i++) y[i] = x[DataW-1-i];
      return y;
    endfunction

    function void note_instruction(logic [3:0] op, instr_bus_t f);
      logic [3:0]       cc, rd;
      logic             s, ex, wr, br;
      logic [15:0]      imm16;
      logic [DataW-1:0] st, res, t, a, b, rm;
      result_t          exp;
      cc    = f.iw[31:28];
      s     = f.iw[20];
      rd    = f.iw[15:12];
      imm16 = {f.iw[19:16], f.iw[11:0]};
      a     = f.first_op;
      b     = f.shifted;
      rm    = f.rev_src;
      st    = flags_word;
      res   = '0;
      ex    = 1'b0;
      wr    = 1'b0;
      br    = 1'b0;
      if (op >= OP_REV && op <= OP_RBIT) begin
        // reversals skip the condition check; a write to the PC is dropped
        if (rd != PcIndex) begin
          case (op)
            OP_REV:   res = {rm[7:0], rm[15:8], rm[23:16], rm[31:24]};
            OP_REV16: res = {rm[23:16], rm[31:24], rm[7:0], rm[15:8]};
            OP_REVSH: res = {{16{rm[7]}}, rm[7:0], rm[15:8]};
            default:  res = bit_mirror(rm);
          endcase
          ex = 1'b1;
          wr = 1'b1;
        end
      end else if (op <= OP_MOVT && cond_holds(cc, st)) begin
        ex = 1'b1;
        case (op)
          OP_TST: begin
            t = a & b;
            st = with_nz(st, t);
            st[FlagC] = f.shc;
          end
          OP_CMP: begin
            t = a - b;
            st = with_nz(st, t);
            st[FlagC] = (a >= b);
            st[FlagV] = (a[31] ^ b[31]) & (a[31] ^ t[31]);
          end
          OP_CMN: begin
            t = a + b;
            st = with_nz(st, t);
            st[FlagC] = (t < a);
            st[FlagV] = ~(a[31] ^ b[31]) & (a[31] ^ t[31]);
          end
          OP_MOVW, OP_MOVT: begin
            res = (op == OP_MOVW) ? {16'h0, imm16} : {imm16, f.old_dest[15:0]};
            if (rd == PcIndex) br = 1'b1;
            else wr = 1'b1;
          end
          default: begin
            case (op)
              OP_ORR:  res = a | b;
              OP_BIC:  res = a & ~b;
              OP_AND:  res = a & b;
              OP_MOV:  res = b;
              default: res = b - a;
            endcase
            if (rd == PcIndex) begin
              br = 1'b1;
              // exception return restores the saved status
              if (s) st = saved_word;
            end else begin
              wr = 1'b1;
              if (s) begin
                st = with_nz(st, res);
                if (op == OP_RSB) begin
                  st[FlagC] = (b >= a);
                  st[FlagV] = (b[31] ^ a[31]) & (b[31] ^ res[31]);
                end else begin
                  st[FlagC] = f.shc;
                end
              end
            end
          end
        endcase
      end
      flags_word        = st;
      exp.executed      = ex;
      exp.reg_write     = wr;
      exp.dest_index    = wr ? rd : '0;
      exp.write_value   = wr ? res : '0;
      exp.branch_taken  = br;
      exp.branch_target = br ? {res[31:1], 1'b0} : '0;
      exp.status_out    = st;
      pending_results.push_back(exp);
    endfunction

    function void compare_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: result %0d %s mismatch: expected %h, actual %h",
                 $time, checked, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction: expected none, actual %h", $time, got);
        return;
      end
      exp = pending_results.pop_front();
      compare_field("executed", DataW'(exp.executed), DataW'(got.executed));
      compare_field("reg_write", DataW'(exp.reg_write), DataW'(got.reg_write));
      compare_field("dest_index", DataW'(exp.dest_index), DataW'(got.dest_index));
      compare_field("write_value", exp.write_value, got.write_value);
      compare_field("branch_taken", DataW'(exp.branch_taken), DataW'(got.branch_taken));
      compare_field("branch_target", exp.branch_target, got.branch_target);
      compare_field("status_out", exp.status_out, got.status_out);
      checked++;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [DataW-1:0]    cfg_data_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic [3:0]          s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  exec_scoreboard sb;
  int src_idle_pct;
  int snk_stall_pct;
  int items_sent;
  int cfg_writes;

  logic_compare_move_execute u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sink back-pressure
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.saved_word = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_instruction(s_axis_tuser_i, s_axis_tdata_i[$bits(instr_bus_t)-1:0]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o[$bits(result_t)-1:0]);
    end
  end

  function automatic int idle_run(int pct);
    int n;
    n = 0;
    while (n < 16 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_bus_t mk_instr(logic [3:0] cc, logic s, logic [3:0] rd,
                                          logic [DataW-1:0] a, logic [DataW-1:0] b,
                                          logic [DataW-1:0] rm, logic [DataW-1:0] old,
                                          logic shc);
    instr_bus_t f;
    f.iw        = $urandom;
    f.iw[31:28] = cc;
    f.iw[20]    = s;
    f.iw[15:12] = rd;
    f.first_op  = a;
    f.shifted   = b;
    f.rev_src   = rm;
    f.old_dest  = old;
    f.shc       = shc;
    return f;
  endfunction

  task automatic send_item(input logic [3:0] op, input instr_bus_t f);
    int gap;
    gap = idle_run(src_idle_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = {{(InDataW - $bits(instr_bus_t)){1'b0}}, f};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic send_random();
    logic [3:0] op;
    logic [3:0] cc, rd;
    if ($urandom_range(99) < 4) op = $urandom_range(1) ? OpSpareHi : OpSpareLo;
    else op = 4'($urandom_range(OP_RBIT));
    cc = ($urandom_range(9) == 0) ? CC_AL : 4'($urandom_range(15));
    rd = ($urandom_range(99) < 20) ? PcIndex : 4'($urandom_range(15));
    send_item(op, mk_instr(cc, 1'($urandom_range(1)), rd, pick_operand(), pick_operand(),
                           pick_operand(), pick_operand(), 1'($urandom_range(1))));
  endtask

  // hold the source until every outstanding result has been checked
  task automatic wait_for_results();
    int guard;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    guard = 0;
    while (sb.pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic write_saved_status(input logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_writes++;
  endtask

  task automatic run_phase(input int n_items, input int src_pct, input int snk_pct,
                           input logic [DataW-1:0] saved);
    wait_for_results();
    write_saved_status(saved);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_for_results();
      send_random();
    end
  endtask

  initial begin
    sb              = new;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    items_sent      = 0;
    cfg_writes      = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    write_saved_status(32'h9000_000F);
    // flag corner cases for the compares
    send_item(OP_CMP, mk_instr(CC_AL, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    send_item(OP_ORR, mk_instr(CC_NE, 1'b1, 4'd1, 32'h1, 32'h2, 32'h0, 32'h0, 1'b1));
    send_item(OP_CMP, mk_instr(CC_AL, 1'b0, 4'd9, 32'h8000_0000, 32'h1, '0, '0, 1'b0));
    send_item(OP_CMN, mk_instr(CC_AL, 1'b1, 4'd0, 32'hFFFF_FFFF, 32'h1, '0, '0, 1'b0));
    send_item(OP_CMN, mk_instr(CC_CS, 1'b0, 4'd3, 32'h7FFF_FFFF, 32'h1, '0, '0, 1'b1));
    send_item(OP_TST, mk_instr(CC_AL, 1'b0, 4'd15, '1, 32'h8000_0000, '0, '0, 1'b0));
    // logical ops and subtract with flag update
    send_item(OP_ORR, mk_instr(CC_AL, 1'b1, 4'd3, 32'h0, 32'h0, '0, '0, 1'b1));
    send_item(OP_BIC, mk_instr(CC_AL, 1'b1, 4'd4, '1, HalfLoMask, '0, '0, 1'b0));
    send_item(OP_AND, mk_instr(CC_GE, 1'b1, 4'd0, '1, '1, '0, '0, 1'b1));
    send_item(OP_MOV, mk_instr(CC_NV, 1'b1, 4'd14, '0, '1, '0, '0, 1'b0));
    send_item(OP_RSB, mk_instr(CC_AL, 1'b1, 4'd2, 32'h1, 32'h0, '0, '0, 1'b0));
    send_item(OP_RSB, mk_instr(CC_AL, 1'b1, 4'd5, '1, 32'h7FFF_FFFF, '0, '0, 1'b1));
    // writes to the PC: exception return, plain branch
    send_item(OP_MOV, mk_instr(CC_AL, 1'b1, PcIndex, '0, 32'h1234_5679, '0, '0, 1'b0));
    send_item(OP_MOV, mk_instr(CC_AL, 1'b0, PcIndex, '0, '1, '0, '0, 1'b1));
    send_item(OP_ORR, mk_instr(CC_AL, 1'b1, PcIndex, 32'h8000_0001, 32'h2, '0, '0, 1'b0));
    // wide moves, including a branch that ignores S
    send_item(OP_MOVW, mk_instr(CC_AL, 1'b0, 4'd7, '0, '0, '0, '1, 1'b0));
    send_item(OP_MOVT, mk_instr(CC_AL, 1'b1, 4'd8, '0, '0, '0, '1, 1'b1));
    send_item(OP_MOVW, mk_instr(CC_AL, 1'b1, PcIndex, '0, '0, '0, '0, 1'b0));
    send_item(OP_MOVT, mk_instr(CC_NV, 1'b1, PcIndex, '0, '0, '0, 32'h0000_FFFF, 1'b0));
    // reversals ignore the condition; into the PC they are dropped
    send_item(OP_REV, mk_instr(CC_EQ, 1'b1, 4'd1, '0, '0, 32'h1234_5678, '0, 1'b0));
    send_item(OP_REV16, mk_instr(CC_NE, 1'b0, 4'd2, '0, '0, 32'hA1B2_C3D4, '0, 1'b0));
    send_item(OP_REVSH, mk_instr(CC_AL, 1'b0, 4'd3, '0, '0, 32'h0000_80FF, '0, 1'b0));
    send_item(OP_RBIT, mk_instr(CC_LE, 1'b0, 4'd4, '0, '0, 32'h0000_0001, '0, 1'b0));
    send_item(OP_REV, mk_instr(CC_AL, 1'b0, PcIndex, '0, '0, '1, '0, 1'b0));
    // undecoded selectors
    send_item(OpSpareLo, mk_instr(CC_AL, 1'b1, 4'd6, '1, '1, '1, '1, 1'b1));
    send_item(OpSpareHi, mk_instr(CC_NV, 1'b1, PcIndex, '1, '1, '1, '1, 1'b1));

    run_phase(112, 0, 0, 32'h0000_0000);
    run_phase(112, 70, 0, 32'hFFFF_FFFF);
    run_phase(112, 0, 70, $urandom);
    run_phase(112, 32, 32, $urandom);

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      sb.mismatches++;
      $display("%0t: missing results: expected %0d more, actual 0",
               $time, sb.pending_results.size());
    end
    $display("Ran %0d instructions (directed corners, then random) under %0d saved-status",
             items_sent, cfg_writes);
    $display("settings with source idle and sink stall mixes; %0d results checked, %0d errors",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0) $display("logic_compare_move_execute test passed");
    else $display("logic_compare_move_execute test failed");
    $finish;
  end

  initial begin
    #2_400_000;
    $display("%0t: timeout", $time);
    $display("logic_compare_move_execute test failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/lcme_pkg.sv
hdl/logic_compare_move_execute.sv
verif/tb_logic_compare_move_execute.sv
